@@ sv/ebd_pkg.sv @@
// Shared types, widths and register codes of the energy beat detector.
package ebd_pkg;

  localparam int MAX_BLOCK_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF       = 16;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WEIGHT_W     = 16;
  localparam int RATIO_W      = 10;
  localparam int RATIO_FRAC_W = 8;
  localparam int COOLDOWN_W   = 8;
  localparam int ENERGY_W     = 16;
  localparam int AVG_W        = 32;

  localparam logic [WEIGHT_W-1:0]   AVG_WEIGHT_RESET      = WEIGHT_W'(5243);
  localparam logic [RATIO_W-1:0]    THRESHOLD_RATIO_RESET = RATIO_W'(346);
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_BLOCKS_RESET = COOLDOWN_W'(24);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVG_WEIGHT,
    REG_THRESHOLD_RATIO,
    REG_COOLDOWN_BLOCKS
  } ebd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MATH,
    ST_EMIT
  } ebd_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_DIV,
    MS_SQRT,
    MS_AVG,
    MS_RATIO,
    MS_DECIDE
  } ebd_math_state_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]   weight;
    logic [RATIO_W-1:0]    ratio;
    logic [COOLDOWN_W-1:0] cooldown;
  } ebd_cfg_t;

  typedef struct packed {
    logic                beat;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] average;
  } ebd_math_res_t;

endpackage

@@ sv/ebd_ifs.sv @@
// Request channels of the energy beat detector: samples, results, register writes.
interface ebd_sample_if #(
  parameter int SAMPLE_BITS = ebd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface ebd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          beat;
  logic [ebd_pkg::ENERGY_W-1:0]  energy;
  logic [ebd_pkg::ENERGY_W-1:0]  average;
  logic                          truncated;

  modport source (output valid, output beat, output energy, output average,
                  output truncated, input ready);
  modport sink (input valid, input beat, input energy, input average,
                input truncated, output ready);
endinterface

interface ebd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ebd_pkg::CFG_IDX_W-1:0]  index;
  logic [ebd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/energy_beat_detector.sv @@
// Each audio sample is accepted, squared in a bit-serial squarer and then added into the
// block sum; no new sample is taken until that is done. A sample past the block bound is
// dropped in its accept cycle. The sample marked last then starts the end-of-block unit,
// which runs a restoring division, a square root, an average update, a threshold
// multiply and a decision step, in that order. One result per block sits in an output
// register; the next block's samples are taken while it waits.
module energy_beat_detector #(
  parameter int MAX_BLOCK_SAMPLES = ebd_pkg::MAX_BLOCK_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = ebd_pkg::SAMPLE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  ebd_cfg_if.sink cfg,
  ebd_sample_if.sink audio,
  ebd_result_if.source report
);
  import ebd_pkg::*;

  localparam int CNT_W     = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SQ_W      = 2*SAMPLE_BITS - 1;
  localparam int SUM_W     = 2*SAMPLE_BITS - 2 + CNT_W;
  localparam int SB        = SAMPLE_BITS;
  localparam int SQ_STEP_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_BLOCK_SAMPLES);

  ebd_state_t state, state_next;

  ebd_cfg_t         cfg_regs;
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] sample_count;
  logic             overflow_seen;
  logic             trunc_block;
  logic             last_held;

  logic [SB-1:0]        mag, mag_a, mul_b;
  logic [SB:0]          sq_hi, sq_sum;
  logic [SB-1:0]        sq_lo;
  logic [SQ_STEP_W-1:0] sq_step;
  logic [2*SB:0]        sq_full;
  logic [SUM_W-1:0]     sum_add, math_sum;

  logic take, drop, accum, math_start, out_load;

  logic          math_done;
  ebd_math_res_t math_res;

  logic                out_valid, out_beat, out_trunc;
  logic [ENERGY_W-1:0] out_energy, out_average;

  assign mag     = audio.sample[SB-1] ? SB'(-audio.sample) : SB'(audio.sample);
  assign sq_sum  = sq_hi + (mul_b[0] ? {1'b0, mag_a} : '0);
  assign sq_full = {sq_hi, sq_lo};
  assign sum_add = square_sum + SUM_W'(sq_full[SQ_W-1:0]);
  assign math_sum = (state == ST_ACCUM) ? sum_add : square_sum;

  assign audio.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  assign report.valid     = out_valid;
  assign report.beat      = out_beat;
  assign report.energy    = out_energy;
  assign report.average   = out_average;
  assign report.truncated = out_trunc;

  ebd_block_math #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_math (
    .clk      (clk),
    .rst      (rst),
    .start    (math_start),
    .sum      (math_sum),
    .count    (sample_count),
    .cfg_regs (cfg_regs),
    .done     (math_done),
    .res      (math_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    take       = 1'b0;
    drop       = 1'b0;
    accum      = 1'b0;
    math_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (audio.valid) begin
          if (sample_count < COUNT_MAX) begin
            take       = 1'b1;
            state_next = ST_SQUARE;
          end else begin
            drop = 1'b1;
            if (audio.last) begin
              math_start = 1'b1;
              state_next = ST_MATH;
            end
          end
        end
      end
      ST_SQUARE: begin
        if (sq_step == SQ_STEP_W'(1)) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        accum = 1'b1;
        if (last_held) begin
          math_start = 1'b1;
          state_next = ST_MATH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MATH: begin
        if (math_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || report.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.weight   <= AVG_WEIGHT_RESET;
      cfg_regs.ratio    <= THRESHOLD_RATIO_RESET;
      cfg_regs.cooldown <= COOLDOWN_BLOCKS_RESET;
      square_sum        <= '0;
      sample_count      <= '0;
      overflow_seen     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_AVG_WEIGHT:      cfg_regs.weight   <= cfg.data[WEIGHT_W-1:0];
          REG_THRESHOLD_RATIO: cfg_regs.ratio    <= cfg.data[RATIO_W-1:0];
          REG_COOLDOWN_BLOCKS: cfg_regs.cooldown <= cfg.data[COOLDOWN_W-1:0];
          default: ;
        endcase
      end
      if (math_start) begin
        square_sum    <= '0;
        sample_count  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (take)  sample_count  <= sample_count + 1'b1;
        if (drop)  overflow_seen <= 1'b1;
        if (accum) square_sum    <= sum_add;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag_a     <= mag;
      mul_b     <= mag;
      sq_hi     <= '0;
      sq_step   <= SQ_STEP_W'(SB);
      last_held <= audio.last;
    end else if (state == ST_SQUARE) begin
      sq_hi   <= {1'b0, sq_sum[SB:1]};
      sq_lo   <= {sq_sum[0], sq_lo[SB-1:1]};
      mul_b   <= mul_b >> 1;
      sq_step <= sq_step - 1'b1;
    end
    if (math_start) trunc_block <= overflow_seen | drop;
    if (out_load) begin
      out_beat    <= math_res.beat;
      out_energy  <= math_res.energy;
      out_average <= math_res.average;
      out_trunc   <= trunc_block;
    end
  end

endmodule

@@ sv/ebd_block_math.sv @@
// End-of-block arithmetic: serial divide, square root, moving average and beat decision.
module ebd_block_math #(
  parameter int MAX_BLOCK_SAMPLES = ebd_pkg::MAX_BLOCK_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = ebd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic [2*SAMPLE_BITS-2+$clog2(MAX_BLOCK_SAMPLES+1)-1:0] sum,
  input  logic [$clog2(MAX_BLOCK_SAMPLES+1)-1:0]                count,
  input  ebd_pkg::ebd_cfg_t                                     cfg_regs,
  output logic                                                  done,
  output ebd_pkg::ebd_math_res_t                                res
);
  import ebd_pkg::*;

  localparam int CNT_W     = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SUM_W     = 2*SAMPLE_BITS - 2 + CNT_W;
  localparam int SB        = SAMPLE_BITS;
  localparam int AVG_STEPS = WEIGHT_W + 1;
  localparam int MAX_STEPS = (SUM_W > AVG_STEPS) ? SUM_W : AVG_STEPS;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int ACC_W     = AVG_W + 2;
  localparam int PROD_W    = AVG_W + RATIO_W;
  localparam int SHIFT_W   = WEIGHT_W + RATIO_FRAC_W;

  ebd_math_state_t mstate, mstate_next;

  logic [STEP_W-1:0]     step;
  logic [SUM_W-1:0]      dvd;
  logic [CNT_W-1:0]      divisor;
  logic [CNT_W-1:0]      rem;
  logic [2*SB-1:0]       rad;
  logic [SB-1:0]         srem;
  logic [SB-1:0]         root;
  logic [ACC_W-1:0]      hi;
  logic [RATIO_W-1:0]    lo;
  logic [WEIGHT_W:0]     c_sh;
  logic [WEIGHT_W-1:0]   w_sh;
  logic [RATIO_W-1:0]    r_sh;
  logic [AVG_W-1:0]      avg;
  logic [COOLDOWN_W-1:0] cooldown;
  logic                  beat;

  logic [CNT_W:0]             rem_sh, rem_diff;
  logic                       q_bit;
  logic [SB+1:0]              srem_sh, trial, s_diff;
  logic                       s_bit;
  logic [SB+ENERGY_W-1:0]     energy_wide;
  logic [ENERGY_W-1:0]        energy;
  logic [AVG_W-1:0]           e_scaled;
  logic [ACC_W-1:0]           avg_sum, rat_sum;
  logic [PROD_W-1:0]          prod, lhs;
  logic [COOLDOWN_W-1:0]      cd_dec;
  logic                       last_step;

  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_bit    = rem_sh >= {1'b0, divisor};

  assign srem_sh = {srem, rad[2*SB-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign s_diff  = srem_sh - trial;
  assign s_bit   = srem_sh >= trial;

  assign energy_wide = {root, ENERGY_W'(0)} >> SB;
  assign energy      = energy_wide[ENERGY_W-1:0];
  assign e_scaled    = {energy, WEIGHT_W'(0)};

  assign avg_sum = hi + (c_sh[0] ? ACC_W'(avg) : '0) + (w_sh[0] ? ACC_W'(e_scaled) : '0);
  assign rat_sum = hi + (r_sh[0] ? ACC_W'(avg) : '0);

  assign prod   = {hi[AVG_W-1:0], lo};
  assign lhs    = PROD_W'({energy, SHIFT_W'(0)});
  assign cd_dec = (cooldown != '0) ? cooldown - 1'b1 : cooldown;

  assign last_step = (step == STEP_W'(1));

  assign res.beat    = beat;
  assign res.energy  = energy;
  assign res.average = avg[AVG_W-1 -: ENERGY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= MS_IDLE;
    end else begin
      mstate <= mstate_next;
    end
  end

  always_comb begin
    mstate_next = mstate;
    done        = 1'b0;
    unique case (mstate)
      MS_IDLE: begin
        if (start) mstate_next = MS_DIV;
      end
      MS_DIV: begin
        if (last_step) mstate_next = MS_SQRT;
      end
      MS_SQRT: begin
        if (last_step) mstate_next = MS_AVG;
      end
      MS_AVG: begin
        if (last_step) mstate_next = MS_RATIO;
      end
      MS_RATIO: begin
        if (last_step) mstate_next = MS_DECIDE;
      end
      MS_DECIDE: begin
        done        = 1'b1;
        mstate_next = MS_IDLE;
      end
      default: mstate_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg      <= '0;
      cooldown <= '0;
      beat     <= 1'b0;
    end else begin
      if (mstate == MS_AVG && last_step) avg <= avg_sum[AVG_W-1:0];
      if (mstate == MS_DECIDE) begin
        if (lhs > prod && cd_dec == '0) begin
          beat     <= 1'b1;
          cooldown <= cfg_regs.cooldown;
        end else begin
          beat     <= 1'b0;
          cooldown <= cd_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (mstate)
      MS_IDLE: begin
        if (start) begin
          dvd     <= sum;
          divisor <= count;
          rem     <= '0;
          rad     <= '0;
          srem    <= '0;
          root    <= '0;
          step    <= STEP_W'(SUM_W);
        end
      end
      MS_DIV: begin
        dvd  <= dvd << 1;
        rem  <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        rad  <= {rad[2*SB-2:0], q_bit};
        step <= last_step ? STEP_W'(SB) : step - 1'b1;
      end
      MS_SQRT: begin
        rad  <= rad << 2;
        srem <= s_bit ? s_diff[SB-1:0] : srem_sh[SB-1:0];
        root <= {root[SB-2:0], s_bit};
        if (last_step) begin
          hi   <= '0;
          c_sh <= {1'b1, WEIGHT_W'(0)} - {1'b0, cfg_regs.weight};
          w_sh <= cfg_regs.weight;
          step <= STEP_W'(AVG_STEPS);
        end else begin
          step <= step - 1'b1;
        end
      end
      MS_AVG: begin
        c_sh <= c_sh >> 1;
        w_sh <= w_sh >> 1;
        if (last_step) begin
          hi   <= '0;
          r_sh <= cfg_regs.ratio;
          step <= STEP_W'(RATIO_W);
        end else begin
          hi   <= {1'b0, avg_sum[ACC_W-1:1]};
          step <= step - 1'b1;
        end
      end
      MS_RATIO: begin
        hi   <= {1'b0, rat_sum[ACC_W-1:1]};
        lo   <= {rat_sum[0], lo[RATIO_W-1:1]};
        r_sh <= r_sh >> 1;
        step <= step - 1'b1;
      end
      MS_DECIDE: begin
        step <= '0;
      end
      default: step <= '0;
    endcase
  end

endmodule
